// ----- hdl/tlpq_pkg.sv -----
// ----------------------------------------------------------------------------
// tlpq_pkg
// Shared types and constants of the three-level priority ready queue.
// ----------------------------------------------------------------------------
package tlpq_pkg;

  localparam int unsigned TLPQ_DEPTH_DEFAULT = 16;
  localparam int unsigned TLPQ_LEVELS        = 3;

  // Priority codes carried by an enqueue
  localparam logic [1:0] PRIO_HIGH = 2'd3;
  localparam logic [1:0] PRIO_MID  = 2'd2;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    LVL_HIGH = 2'd0,
    LVL_MID  = 2'd1,
    LVL_LOW  = 2'd2
  } level_t;

  typedef struct packed {
    logic [15:0] task_id;
    logic [31:0] stack_pointer;
  } entry_t;

  typedef struct packed {
    op_t         operation;
    logic [15:0] task_id;
    logic [31:0] stack_pointer;
    logic [1:0]  priority_req;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] out_task_id;
    logic [31:0] out_stack_pointer;
    level_t      out_level;
  } out_item_t;

endpackage

// ----- hdl/three_level_priority_ready_queue_core.sv -----
// ----------------------------------------------------------------------------
// three_level_priority_ready_queue_core
// Strict-priority ready queue with three FIFO levels for a task scheduler.
// ----------------------------------------------------------------------------
// Takes one transfer per cycle on the in_ channel while in_ready is high and
// returns exactly one result per transfer, in order. An enqueue (operation 0)
// appends {task_id, stack_pointer} to the high level for priority 3, mid for
// 2 and low for 0 or 1; if that level already holds QUEUE_DEPTH entries the
// task is dropped and status 2 comes back with the targeted level. A dequeue
// (operation 1) pops the oldest entry of the highest non-empty level and
// returns it with that level; with all levels empty it returns status 1,
// level 0 and zero payload. The path is set by the entry RAM: queue pointers
// and counts update at the accept edge and the RAM read is registered
// alongside stage 1, then the result register forms the outgoing transfer.
// A stage plus the result register let a new transfer be taken while an
// earlier result waits on out_ready. No clearing pass after reset; entry
// contents need no reset.
module three_level_priority_ready_queue_core
  import tlpq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = TLPQ_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int unsigned SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(QUEUE_DEPTH);

  // Per-level queue pointers and occupancy
  logic [SLOT_W-1:0] head_r [TLPQ_LEVELS];
  logic [SLOT_W-1:0] head_nxt [TLPQ_LEVELS];
  logic [SLOT_W-1:0] tail_r [TLPQ_LEVELS];
  logic [SLOT_W-1:0] tail_nxt [TLPQ_LEVELS];
  logic [CNT_W-1:0]  cnt_r [TLPQ_LEVELS];
  logic [CNT_W-1:0]  cnt_nxt [TLPQ_LEVELS];

  // Stage 1: decision made at accept, RAM read in flight
  logic    s1_vld_r;
  status_t s1_status_r;
  level_t  s1_level_r;
  logic    s1_hit_r;   // dequeue found an entry: take RAM data

  // Result register
  logic      out_vld_r;
  out_item_t out_data_r;

  logic    in_acc;
  logic    s1_adv;
  level_t  enq_level;
  level_t  deq_level;
  logic    deq_found;
  logic    enq_full;
  status_t acc_status;
  level_t  acc_level;
  logic    ram_we;
  logic    ram_re;
  entry_t  ram_wdata;
  entry_t  ram_rdata;

  // Handshake: stage 1 moves on when the result register is free or drains
  assign s1_adv   = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  // Level targeted by an enqueue
  always_comb begin
    priority if (in_data.priority_req == PRIO_HIGH) begin
      enq_level = LVL_HIGH;
    end else if (in_data.priority_req == PRIO_MID) begin
      enq_level = LVL_MID;
    end else begin
      enq_level = LVL_LOW;
    end
  end

  // Highest non-empty level for a dequeue
  always_comb begin
    deq_found = 1'b1;
    priority if (cnt_r[LVL_HIGH] != '0) begin
      deq_level = LVL_HIGH;
    end else if (cnt_r[LVL_MID] != '0) begin
      deq_level = LVL_MID;
    end else if (cnt_r[LVL_LOW] != '0) begin
      deq_level = LVL_LOW;
    end else begin
      deq_level = LVL_HIGH;
      deq_found = 1'b0;
    end
  end

  assign enq_full = (cnt_r[enq_level] == CNT_FULL);

  always_comb begin
    for (int i = 0; i < TLPQ_LEVELS; i++) begin
      head_nxt[i] = head_r[i];
      tail_nxt[i] = tail_r[i];
      cnt_nxt[i]  = cnt_r[i];
    end
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    acc_status = ST_DONE;
    acc_level  = LVL_HIGH;
    if (in_acc) begin
      unique case (in_data.operation)
        OP_ENQ: begin
          acc_level = enq_level;
          if (enq_full) begin
            acc_status = ST_FULL;
          end else begin
            ram_we = 1'b1;
            tail_nxt[enq_level] = (tail_r[enq_level] == SLOT_LAST) ? '0 :
                                  tail_r[enq_level] + 1'b1;
            cnt_nxt[enq_level]  = cnt_r[enq_level] + 1'b1;
          end
        end
        OP_DEQ: begin
          acc_level = deq_level;
          if (!deq_found) begin
            acc_status = ST_EMPTY;
          end else begin
            ram_re = 1'b1;
            head_nxt[deq_level] = (head_r[deq_level] == SLOT_LAST) ? '0 :
                                  head_r[deq_level] + 1'b1;
            cnt_nxt[deq_level]  = cnt_r[deq_level] - 1'b1;
          end
        end
        default: begin
          acc_status = ST_DONE;
        end
      endcase
    end
  end

  assign ram_wdata.task_id       = in_data.task_id;
  assign ram_wdata.stack_pointer = in_data.stack_pointer;

  tlpq_entry_ram #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_entry_ram (
    .clk      (clk),
    .wr_en    (ram_we),
    .wr_level (enq_level),
    .wr_slot  (tail_r[enq_level]),
    .wr_data  (ram_wdata),
    .rd_en    (ram_re),
    .rd_level (deq_level),
    .rd_slot  (head_r[deq_level]),
    .rd_data  (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TLPQ_LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < TLPQ_LEVELS; i++) begin
        head_r[i] <= head_nxt[i];
        tail_r[i] <= tail_nxt[i];
        cnt_r[i]  <= cnt_nxt[i];
      end
    end
  end

  // Stage 1 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_status_r <= acc_status;
      s1_level_r  <= acc_level;
      s1_hit_r    <= ram_re;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r.status            <= s1_status_r;
      out_data_r.out_level         <= s1_level_r;
      out_data_r.out_task_id       <= s1_hit_r ? ram_rdata.task_id : '0;
      out_data_r.out_stack_pointer <= s1_hit_r ? ram_rdata.stack_pointer : '0;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < TLPQ_LEVELS; g++) begin : g_lvl_chk
    a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
      cnt_r[g] <= CNT_FULL)
      else $error("level occupancy above depth");

    a_ptr_match : assert property (@(posedge clk) disable iff (!rst_n)
      (cnt_r[g] == '0 || cnt_r[g] == CNT_FULL) |-> head_r[g] == tail_r[g])
      else $error("head and tail disagree with occupancy");
  end

  a_empty_level : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && s1_status_r == ST_EMPTY) |-> (s1_level_r == LVL_HIGH && !s1_hit_r))
    else $error("empty dequeue carries level or data");

  a_s1_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !s1_adv) |=> (s1_vld_r && $stable(s1_status_r) && $stable(s1_level_r)))
    else $error("stalled stage 1 lost its transfer");

endmodule

// ----- hdl/tlpq_entry_ram.sv -----
// ----------------------------------------------------------------------------
// tlpq_entry_ram
// Entry storage for all three levels: one write port, one registered read.
// ----------------------------------------------------------------------------
module tlpq_entry_ram
  import tlpq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = TLPQ_DEPTH_DEFAULT,
  localparam int unsigned SLOT_W     = $clog2(QUEUE_DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  level_t            wr_level,
  input  logic [SLOT_W-1:0] wr_slot,
  input  entry_t            wr_data,
  input  logic              rd_en,
  input  level_t            rd_level,
  input  logic [SLOT_W-1:0] rd_slot,
  output entry_t            rd_data
);

  entry_t mem [TLPQ_LEVELS][QUEUE_DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_level][wr_slot] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_level][rd_slot];
    end
  end

  assign rd_data = rd_data_r;

endmodule
